>>> hw/rtl/fprc8_pkg.sv
// Shared types, constants and the CRC-8 byte update for the framed packet receiver.
// No dependencies; used by fprc8_parser and framed_packet_receiver_crc8_top.

package fprc8_pkg;

   // Frame marker and CRC polynomial.
   localparam logic [7:0] MARKER_BYTE = 8'h41;
   localparam logic [7:0] CRC_POLY    = 8'h07;

   // Reset values of the configuration registers.
   localparam logic [15:0] TIMEOUT_RESET   = 16'd200;
   localparam logic [7:0]  MAX_LEN_RESET   = 8'd255;
   localparam logic        CRC_EN_RESET    = 1'b1;

   // Configuration register indexes.
   localparam int unsigned CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_TIMEOUT_TICKS = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_PAYLOAD   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CRC_ENABLE    = 2'd2;
   localparam int unsigned CSR_DATA_W = 16;

   // Input word commands.
   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   // Live configuration as seen by the parser.
   typedef struct packed {
      logic [15:0] timeout_ticks;
      logic [7:0]  max_payload;
      logic        crc_enable;
   } cfg_type;

   // One result word, with a flag that says whether the input word produced one.
   typedef struct packed {
      logic       present;
      logic       payload_valid;
      logic [7:0] payload_index;
      logic [7:0] payload_byte;
      logic       packet_done;
      logic       packet_good;
      logic [7:0] packet_length;
   } result_type;

   // CRC-8, MSB first, one byte per call.
   function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int i = 0; i < 8; i++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

>>> hw/rtl/fprc8_parser.sv
// Frame parser state machine: hunts for markers, tracks length, count, CRC and idle time.
// Depends on fprc8_pkg for the configuration and result types and the CRC update.

module fprc8_parser (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic                 command,
   input  logic [7:0]           data_byte,
   input  fprc8_pkg::cfg_type   cfg,
   output fprc8_pkg::result_type result
);

   typedef enum logic [2:0] {
      PH_HUNT1,
      PH_HUNT2,
      PH_LEN,
      PH_DATA,
      PH_CRC
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [7:0]  exp_len_ff, exp_len_in;
   logic [7:0]  count_ff, count_in;
   logic [7:0]  crc_ff, crc_in;
   logic [15:0] idle_ff, idle_in;

   logic        timed_out;
   phase_type   cur_phase;
   logic [7:0]  cur_len;
   logic [7:0]  cur_count;
   logic [7:0]  cur_crc;
   logic [7:0]  count_next;
   logic [7:0]  crc_next;
   logic [7:0]  crc_first;

   // A byte that arrives after too long an idle spell sees a restarted parser.
   assign timed_out = (idle_ff > cfg.timeout_ticks);
   assign cur_phase = timed_out ? PH_HUNT1 : phase_ff;
   assign cur_len   = timed_out ? 8'd0 : exp_len_ff;
   assign cur_count = timed_out ? 8'd0 : count_ff;
   assign cur_crc   = timed_out ? 8'd0 : crc_ff;

   assign count_next = cur_count + 8'd1;
   assign crc_next   = fprc8_pkg::crc8_step(cur_crc, data_byte);
   assign crc_first  = fprc8_pkg::crc8_step(8'd0, data_byte);

   // Next state and result for the word in hand.
   always_comb begin
      phase_in   = phase_ff;
      exp_len_in = exp_len_ff;
      count_in   = count_ff;
      crc_in     = crc_ff;
      idle_in    = idle_ff;
      result     = '0;

      if (command == fprc8_pkg::CMD_TICK) begin
         // Idle tick: saturating count, no word out.
         if (idle_ff != '1) begin
            idle_in = idle_ff + 16'd1;
         end
      end else begin
         idle_in    = '0;
         phase_in   = cur_phase;
         exp_len_in = cur_len;
         count_in   = cur_count;
         crc_in     = cur_crc;
         unique case (cur_phase)
            PH_HUNT1: begin
               phase_in = (data_byte == fprc8_pkg::MARKER_BYTE) ? PH_HUNT2 : PH_HUNT1;
            end
            PH_HUNT2: begin
               if (data_byte == fprc8_pkg::MARKER_BYTE) begin
                  phase_in = PH_LEN;
               end else begin
                  phase_in   = PH_HUNT1;
                  exp_len_in = '0;
                  count_in   = '0;
                  crc_in     = '0;
               end
            end
            PH_LEN: begin
               exp_len_in = data_byte;
               count_in   = '0;
               crc_in     = crc_first;
               priority if (data_byte > cfg.max_payload) begin
                  phase_in   = PH_HUNT1;
                  exp_len_in = '0;
                  crc_in     = '0;
               end else if (data_byte != 8'd0) begin
                  phase_in = PH_DATA;
               end else if (cfg.crc_enable) begin
                  phase_in = PH_CRC;
               end else begin
                  // Empty frame without CRC ends at once as good.
                  result.present     = 1'b1;
                  result.packet_done = 1'b1;
                  result.packet_good = 1'b1;
                  phase_in   = PH_HUNT1;
                  exp_len_in = '0;
                  crc_in     = '0;
               end
            end
            PH_DATA: begin
               result.present       = 1'b1;
               result.payload_valid = 1'b1;
               result.payload_index = cur_count;
               result.payload_byte  = data_byte;
               crc_in   = crc_next;
               count_in = count_next;
               if (count_next >= cur_len) begin
                  if (cfg.crc_enable) begin
                     phase_in = PH_CRC;
                  end else begin
                     // Last payload byte also closes the frame.
                     result.packet_done   = 1'b1;
                     result.packet_good   = 1'b1;
                     result.packet_length = cur_len;
                     phase_in   = PH_HUNT1;
                     exp_len_in = '0;
                     count_in   = '0;
                     crc_in     = '0;
                  end
               end
            end
            PH_CRC: begin
               result.present       = 1'b1;
               result.packet_done   = 1'b1;
               result.packet_good   = (cur_crc == data_byte);
               result.packet_length = (cur_crc == data_byte) ? cur_len : 8'd0;
               phase_in   = PH_HUNT1;
               exp_len_in = '0;
               count_in   = '0;
               crc_in     = '0;
            end
            default: begin
               phase_in   = PH_HUNT1;
               exp_len_in = '0;
               count_in   = '0;
               crc_in     = '0;
            end
         endcase
      end
   end

   // Parser state.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HUNT1;
         exp_len_ff <= '0;
         count_ff   <= '0;
         crc_ff     <= '0;
         idle_ff    <= '0;
      end else if (step) begin
         phase_ff   <= phase_in;
         exp_len_ff <= exp_len_in;
         count_ff   <= count_in;
         crc_ff     <= crc_in;
         idle_ff    <= idle_in;
      end
   end

endmodule

>>> hw/rtl/framed_packet_receiver_crc8_top.sv
// Top level of the framed packet receiver: channel registers and configuration registers.
// Depends on fprc8_pkg and instantiates fprc8_parser.
//
// Usage: words enter on the req_ channel (req_command 0 = received byte in req_data_byte,
// 1 = one idle tick). Frames are 'A','A', length, payload and, with CRC enabled, a CRC-8
// byte (polynomial 0x07, initial 0, over length and payload). Each payload byte leaves on
// the rsp_ channel with its index; the word that ends a frame carries done, good and the
// length. Ticks, markers and the length byte produce no word out, except the length byte of an
// empty frame with CRC disabled. A word taken on req_ waits in the input register, is
// processed by the parser into the result register, and its result is offered on rsp_.
// Throughput is one word per cycle while rsp_ does not stall, set by the combinational
// parser update between the input register and the result register.
// If the rsp_ side stalls, the result register holds; the input register still takes a
// word, and req_ready falls only while both registers are occupied and blocked.
// Configuration is written on the csr_ channel (index 0 timeout_ticks, 1 max_payload,
// 2 crc_enable); the user writes it only while the block is idle (not enforced); csr_ready is always high.
// Synchronous reset empties both registers, restarts the parser and restores the
// configuration defaults (timeout 200, max payload 255, CRC on).

module framed_packet_receiver_crc8_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_command,
   input  logic [7:0]                           req_data_byte,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_payload_valid,
   output logic [7:0]                           rsp_payload_index,
   output logic [7:0]                           rsp_payload_byte,
   output logic                                 rsp_packet_done,
   output logic                                 rsp_packet_good,
   output logic [7:0]                           rsp_packet_length,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [fprc8_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [fprc8_pkg::CSR_DATA_W-1:0]     csr_data
);

   fprc8_pkg::cfg_type    cfg_ff;
   fprc8_pkg::result_type result;

   logic       in_valid_ff;
   logic       in_command_ff;
   logic [7:0] in_byte_ff;
   logic       out_valid_ff;
   logic       out_free;
   logic       step;

   // Configuration registers.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.timeout_ticks <= fprc8_pkg::TIMEOUT_RESET;
         cfg_ff.max_payload   <= fprc8_pkg::MAX_LEN_RESET;
         cfg_ff.crc_enable    <= fprc8_pkg::CRC_EN_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            fprc8_pkg::CSR_TIMEOUT_TICKS: cfg_ff.timeout_ticks <= csr_data;
            fprc8_pkg::CSR_MAX_PAYLOAD:   cfg_ff.max_payload   <= csr_data[7:0];
            fprc8_pkg::CSR_CRC_ENABLE:    cfg_ff.crc_enable    <= csr_data[0];
            default: ;
         endcase
      end
   end

   // Flow control: the word in the input register is processed when the result
   // register is free or being emptied.
   assign out_free  = !out_valid_ff || rsp_ready;
   assign step      = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_command_ff <= req_command;
         in_byte_ff    <= req_data_byte;
      end
   end

   fprc8_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .command   (in_command_ff),
      .data_byte (in_byte_ff),
      .cfg       (cfg_ff),
      .result    (result)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= step && result.present;
      end
   end

   always_ff @(posedge clock) begin
      if (step && result.present) begin
         rsp_payload_valid <= result.payload_valid;
         rsp_payload_index <= result.payload_index;
         rsp_payload_byte  <= result.payload_byte;
         rsp_packet_done   <= result.packet_done;
         rsp_packet_good   <= result.packet_good;
         rsp_packet_length <= result.packet_length;
      end
   end

   assign rsp_valid = out_valid_ff;

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for framed_packet_receiver_crc8_top: directed frames, then random
// traffic under several register settings, checked word by word against a built-in predictor.
// Depends on fprc8_pkg and the receiver RTL only.

typedef enum logic [2:0] {
   HUNT_FIRST,
   HUNT_SECOND,
   GET_LENGTH,
   GET_PAYLOAD,
   GET_CRC
} parse_phase_type;

// CRC-8 update, polynomial 0x07, data bits taken MSB first through the feedback tap.
function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] data);
   logic [7:0] c;
   logic       fb;
   c = crc;
   for (int i = 7; i >= 0; i--) begin
      fb = c[7] ^ data[i];
      c  = {c[6:0], 1'b0};
      if (fb) begin
         c = c ^ fprc8_pkg::CRC_POLY;
      end
   end
   return c;
endfunction

// Frame predictor and store of the result words still owed by the block.
class frame_scoreboard;
   fprc8_pkg::cfg_type    settings;
   parse_phase_type       phase;
   logic [7:0]            want_length;
   logic [7:0]            byte_count;
   logic [7:0]            running_crc;
   logic [15:0]           idle_ticks;
   fprc8_pkg::result_type expected_words[$];
   int                    errors;

   function new();
      settings.timeout_ticks = fprc8_pkg::TIMEOUT_RESET;
      settings.max_payload   = fprc8_pkg::MAX_LEN_RESET;
      settings.crc_enable    = fprc8_pkg::CRC_EN_RESET;
      restart();
      idle_ticks = 16'd0;
      errors     = 0;
   endfunction

   function void restart();
      phase       = HUNT_FIRST;
      want_length = 8'd0;
      byte_count  = 8'd0;
      running_crc = 8'd0;
   endfunction

   function void set_register(input logic [fprc8_pkg::CSR_INDEX_W-1:0] idx,
                              input logic [fprc8_pkg::CSR_DATA_W-1:0] value);
      case (idx)
         fprc8_pkg::CSR_TIMEOUT_TICKS: settings.timeout_ticks = value;
         fprc8_pkg::CSR_MAX_PAYLOAD:   settings.max_payload   = value[7:0];
         fprc8_pkg::CSR_CRC_ENABLE:    settings.crc_enable    = value[0];
         default: ;
      endcase
   endfunction

   // Advances the parser by one accepted word and queues the result word it causes.
   function void note_word(input logic cmd, input logic [7:0] value);
      fprc8_pkg::result_type r;
      bit                    emit;
      r    = '0;
      emit = 1'b0;
      if (cmd == fprc8_pkg::CMD_TICK) begin
         if (idle_ticks != 16'hFFFF) begin
            idle_ticks = idle_ticks + 16'd1;
         end
      end else begin
         // A byte after too long a silence starts from scratch.
         if (idle_ticks > settings.timeout_ticks) begin
            restart();
         end
         idle_ticks = 16'd0;
         case (phase)
            HUNT_FIRST: begin
               phase = (value == fprc8_pkg::MARKER_BYTE) ? HUNT_SECOND : HUNT_FIRST;
            end
            HUNT_SECOND: begin
               if (value == fprc8_pkg::MARKER_BYTE) begin
                  phase = GET_LENGTH;
               end else begin
                  restart();
               end
            end
            GET_LENGTH: begin
               want_length = value;
               byte_count  = 8'd0;
               running_crc = crc8_next(8'd0, value);
               if (value > settings.max_payload) begin
                  restart();
               end else if (value != 8'd0) begin
                  phase = GET_PAYLOAD;
               end else if (settings.crc_enable) begin
                  phase = GET_CRC;
               end else begin
                  r.packet_done = 1'b1;
                  r.packet_good = 1'b1;
                  emit = 1'b1;
                  restart();
               end
            end
            GET_PAYLOAD: begin
               r.payload_valid = 1'b1;
               r.payload_index = byte_count;
               r.payload_byte  = value;
               emit = 1'b1;
               running_crc = crc8_next(running_crc, value);
               byte_count  = byte_count + 8'd1;
               if (byte_count >= want_length) begin
                  if (settings.crc_enable) begin
                     phase = GET_CRC;
                  end else begin
                     r.packet_done   = 1'b1;
                     r.packet_good   = 1'b1;
                     r.packet_length = want_length;
                     restart();
                  end
               end
            end
            GET_CRC: begin
               r.packet_done   = 1'b1;
               r.packet_good   = (running_crc == value);
               r.packet_length = r.packet_good ? want_length : 8'd0;
               emit = 1'b1;
               restart();
            end
            default: restart();
         endcase
      end
      if (emit) begin
         expected_words.push_back(r);
      end
   endfunction

   function void compare_field(input string name, input int unsigned want,
                               input int unsigned seen);
      if (want != seen) begin
         errors++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, seen);
      end
   endfunction

   // Compares one accepted result word with the oldest one owed.
   function void check_word(input fprc8_pkg::result_type seen);
      fprc8_pkg::result_type want;
      if (expected_words.size() == 0) begin
         errors++;
         $display("%0t: unexpected result word, expected none, actual %h", $time, seen);
         return;
      end
      want = expected_words.pop_front();
      compare_field("payload_valid", want.payload_valid, seen.payload_valid);
      compare_field("payload_index", want.payload_index, seen.payload_index);
      compare_field("payload_byte",  want.payload_byte,  seen.payload_byte);
      compare_field("packet_done",   want.packet_done,   seen.packet_done);
      compare_field("packet_good",   want.packet_good,   seen.packet_good);
      compare_field("packet_length", want.packet_length, seen.packet_length);
   endfunction
endclass

module tb_top;

   logic                              clock;
   logic                              reset;
   logic                              req_valid;
   logic                              req_ready;
   logic                              req_command;
   logic [7:0]                        req_data_byte;
   logic                              rsp_valid;
   logic                              rsp_ready;
   logic                              rsp_payload_valid;
   logic [7:0]                        rsp_payload_index;
   logic [7:0]                        rsp_payload_byte;
   logic                              rsp_packet_done;
   logic                              rsp_packet_good;
   logic [7:0]                        rsp_packet_length;
   logic                              csr_valid;
   logic                              csr_ready;
   logic [fprc8_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [fprc8_pkg::CSR_DATA_W-1:0]  csr_data;

   frame_scoreboard sb;
   // When set, neither side inserts gaps or stalls.
   bit              calm = 1'b0;

   framed_packet_receiver_crc8_top u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_command       (req_command),
      .req_data_byte     (req_data_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_payload_valid (rsp_payload_valid),
      .rsp_payload_index (rsp_payload_index),
      .rsp_payload_byte  (rsp_payload_byte),
      .rsp_packet_done   (rsp_packet_done),
      .rsp_packet_good   (rsp_packet_good),
      .rsp_packet_length (rsp_packet_length),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Sends one input word after a random gap and notes it once accepted.
   task automatic send_word(input logic cmd, input logic [7:0] value);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 4);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_command   <= cmd;
      req_data_byte <= value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_word(cmd, value);
   endtask

   task automatic send_ticks(input int count);
      for (int i = 0; i < count; i++) begin
         send_word(fprc8_pkg::CMD_TICK, 8'($urandom_range(0, 255)));
      end
   endtask

   // A frame byte, sometimes after up to timeout+2 ticks (timeout under 32) or up to 3 ticks.
   task automatic frame_byte(input logic [7:0] value);
      int limit;
      limit = int'(sb.settings.timeout_ticks);
      if ($urandom_range(0, 15) == 0) begin
         send_ticks((limit < 32) ? $urandom_range(0, limit + 2) : $urandom_range(0, 3));
      end
      send_word(fprc8_pkg::CMD_BYTE, value);
   endtask

   task automatic write_register(input logic [fprc8_pkg::CSR_INDEX_W-1:0] idx,
                                 input logic [fprc8_pkg::CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.set_register(idx, value);
   endtask

   task automatic apply_settings(input int tmo, input int max_len, input int crc_on);
      write_register(fprc8_pkg::CSR_TIMEOUT_TICKS, fprc8_pkg::CSR_DATA_W'(tmo));
      write_register(fprc8_pkg::CSR_MAX_PAYLOAD, fprc8_pkg::CSR_DATA_W'(max_len));
      write_register(fprc8_pkg::CSR_CRC_ENABLE, fprc8_pkg::CSR_DATA_W'(crc_on));
      csr_valid <= 1'b0;
   endtask

   // Waits until every owed word has arrived and the pipeline has emptied.
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.expected_words.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   // Mostly well-formed frames with random content, plus noise and broken frames.
   task automatic traffic(input int budget);
      int         sent;
      int         kind;
      int         len;
      int         mx;
      int         parts;
      logic [7:0] crc;
      logic [7:0] value;
      sent = 0;
      while (sent < budget) begin
         if ($urandom_range(0, 19) == 0) begin
            calm = !calm;
         end
         kind = $urandom_range(0, 9);
         mx   = int'(sb.settings.max_payload);
         case ($urandom_range(0, 15))
            0:       len = mx;
            1:       len = 0;
            default: len = $urandom_range(1, (mx < 12) ? mx : 12);
         endcase
         if (kind == 2 && mx < 255) begin
            len = $urandom_range(mx + 1, 255);
         end
         if (kind == 0) begin
            // Line noise, sometimes holding stray markers.
            parts = $urandom_range(1, 3);
            for (int i = 0; i < parts; i++) begin
               value = ($urandom_range(0, 3) == 0) ? fprc8_pkg::MARKER_BYTE
                                                   : 8'($urandom_range(0, 255));
               frame_byte(value);
            end
            sent += parts;
         end else if (kind == 1) begin
            // Broken second marker.
            value = 8'($urandom_range(0, 255));
            if (value == fprc8_pkg::MARKER_BYTE) begin
               value = ~value;
            end
            frame_byte(fprc8_pkg::MARKER_BYTE);
            frame_byte(value);
            sent += 2;
         end else begin
            frame_byte(fprc8_pkg::MARKER_BYTE);
            frame_byte(fprc8_pkg::MARKER_BYTE);
            frame_byte(8'(len));
            crc   = crc8_next(8'd0, 8'(len));
            parts = (kind == 4) ? $urandom_range(0, len) : len;
            for (int i = 0; i < parts; i++) begin
               value = 8'($urandom_range(0, 255));
               frame_byte(value);
               crc = crc8_next(crc, value);
            end
            if (kind != 2 && kind != 4 && sb.settings.crc_enable) begin
               if (kind == 3) begin
                  crc = crc ^ 8'($urandom_range(1, 255));
               end
               frame_byte(crc);
            end
            sent += parts + 4;
         end
      end
   endtask

   // Result side: random stalls, every accepted word checked.
   initial begin
      int                    stall;
      fprc8_pkg::result_type seen;
      rsp_ready <= 1'b0;
      repeat (4) @(posedge clock);
      forever begin
         stall = calm ? 0 : $urandom_range(0, 4);
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         seen = '0;
         seen.payload_valid = rsp_payload_valid;
         seen.payload_index = rsp_payload_index;
         seen.payload_byte  = rsp_payload_byte;
         seen.packet_done   = rsp_packet_done;
         seen.packet_good   = rsp_packet_good;
         seen.packet_length = rsp_packet_length;
         sb.check_word(seen);
      end
   end

   // Stimulus sequence.
   initial begin
      int tmo_list[7];
      int max_list[7];
      int crc_list[7];
      tmo_list = '{3, 0, 65535, 5, 10, 65535, 1};
      max_list = '{16, 1, 255, 8, 255, 4, 40};
      crc_list = '{1, 0, 0, 0, 1, 1, 0};
      sb = new();
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_command   <= fprc8_pkg::CMD_BYTE;
      req_data_byte <= 8'd0;
      csr_valid     <= 1'b0;
      csr_index     <= fprc8_pkg::CSR_TIMEOUT_TICKS;
      csr_data      <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: good frame with extreme payload values and a tick inside it.
      send_word(fprc8_pkg::CMD_BYTE, fprc8_pkg::MARKER_BYTE);
      send_word(fprc8_pkg::CMD_BYTE, fprc8_pkg::MARKER_BYTE);
      send_word(fprc8_pkg::CMD_BYTE, 8'd2);
      send_word(fprc8_pkg::CMD_TICK, 8'hFF);
      send_word(fprc8_pkg::CMD_BYTE, 8'h00);
      send_word(fprc8_pkg::CMD_BYTE, 8'hFF);
      send_word(fprc8_pkg::CMD_BYTE,
                crc8_next(crc8_next(crc8_next(8'd0, 8'd2), 8'h00), 8'hFF));
      // Zero length frame, the CRC byte follows the length directly.
      send_word(fprc8_pkg::CMD_BYTE, fprc8_pkg::MARKER_BYTE);
      send_word(fprc8_pkg::CMD_BYTE, fprc8_pkg::MARKER_BYTE);
      send_word(fprc8_pkg::CMD_BYTE, 8'd0);
      send_word(fprc8_pkg::CMD_BYTE, crc8_next(8'd0, 8'd0));
      // Wrong CRC byte.
      send_word(fprc8_pkg::CMD_BYTE, fprc8_pkg::MARKER_BYTE);
      send_word(fprc8_pkg::CMD_BYTE, fprc8_pkg::MARKER_BYTE);
      send_word(fprc8_pkg::CMD_BYTE, 8'd1);
      send_word(fprc8_pkg::CMD_BYTE, 8'h80);
      send_word(fprc8_pkg::CMD_BYTE, crc8_next(crc8_next(8'd0, 8'd1), 8'h80) ^ 8'h01);
      // Bad second marker, then a frame that must still be found.
      send_word(fprc8_pkg::CMD_BYTE, fprc8_pkg::MARKER_BYTE);
      send_word(fprc8_pkg::CMD_BYTE, 8'h7E);
      send_word(fprc8_pkg::CMD_BYTE, fprc8_pkg::MARKER_BYTE);
      send_word(fprc8_pkg::CMD_BYTE, fprc8_pkg::MARKER_BYTE);
      send_word(fprc8_pkg::CMD_BYTE, 8'd1);
      send_word(fprc8_pkg::CMD_BYTE, 8'h55);
      send_word(fprc8_pkg::CMD_BYTE, crc8_next(crc8_next(8'd0, 8'd1), 8'h55));
      drain();

      // Random phases, one register setting each.
      for (int p = 0; p < 7; p++) begin
         apply_settings(tmo_list[p], max_list[p], crc_list[p]);
         traffic(290);
         drain();
      end

      if (sb.errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #(12 * 1200000);
      $display("== FAIL ==");
      $finish;
   end

endmodule
